### hw/rtl/ordered_list_store_delete_ops_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list store
// Wrappers that compile to concurrent assertions, or to nothing when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_DELETE_OPS_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_DELETE_OPS_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge outside reset
`define OLSD_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("olsd: invariant violated");

// consequent holds in the same cycle as the antecedent
`define OLSD_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olsd: implication violated");

// consequent holds in the cycle after the antecedent
`define OLSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olsd: next-cycle implication violated");

`else

`define OLSD_ASSERT_ALWAYS(name, clk, rst, cond)
`define OLSD_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define OLSD_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/olsd_pkg.sv
// ----------------------------------------------------------------------------
// olsd_pkg
// Request and status codes, and the command and status bundles that join
// the controller and the datapath of the ordered list store.
// ----------------------------------------------------------------------------
package olsd_pkg;

   typedef enum logic [2:0] {
      REQ_INSERT_HEAD  = 3'd0,
      REQ_DELETE_HEAD  = 3'd1,
      REQ_DELETE_TAIL  = 3'd2,
      REQ_DELETE_INDEX = 3'd3,
      REQ_DELETE_VALUE = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_BAD_IDX  = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_FULL     = 3'd4
   } status_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_IDLE       = 3'd0,
      OP_INSERT     = 3'd1,
      OP_POP_HEAD   = 3'd2,
      OP_POP_TAIL   = 3'd3,
      OP_REPORT     = 3'd4,
      OP_WALK_START = 3'd5,
      OP_WALK_STEP  = 3'd6,
      OP_WALK_END   = 3'd7
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type code;      // status reported by OP_REPORT
      logic       by_value;  // walk drops matches of the key, else one index
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic idx_bad;
      logic walk_done;
   } dp_stat_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WALK = 2'b10
   } ctrl_state_type;

endpackage

### hw/rtl/olsd_ctrl.sv
// ----------------------------------------------------------------------------
// olsd_ctrl
// Request decoder and sequencer: picks the datapath operation for each
// transaction, runs the compaction walk and raises the result strobe.
// ----------------------------------------------------------------------------
`include "ordered_list_store_delete_ops_top_defines.svh"

module olsd_ctrl
   import olsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_type,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_valid
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '{op: OP_IDLE, code: STAT_OK, by_value: 1'b0};
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_INSERT_HEAD: begin
                     if (stat.full) begin
                        cmd.op   = OP_REPORT;
                        cmd.code = STAT_FULL;
                     end else begin
                        cmd.op = OP_INSERT;
                     end
                  end
                  REQ_DELETE_HEAD: begin
                     if (stat.empty) begin
                        cmd.op   = OP_REPORT;
                        cmd.code = STAT_EMPTY;
                     end else begin
                        cmd.op = OP_POP_HEAD;
                     end
                  end
                  REQ_DELETE_TAIL: begin
                     if (stat.empty) begin
                        cmd.op   = OP_REPORT;
                        cmd.code = STAT_EMPTY;
                     end else begin
                        cmd.op = OP_POP_TAIL;
                     end
                  end
                  REQ_DELETE_INDEX: begin
                     if (stat.empty) begin
                        cmd.op   = OP_REPORT;
                        cmd.code = STAT_EMPTY;
                     end else if (stat.idx_bad) begin
                        cmd.op   = OP_REPORT;
                        cmd.code = STAT_BAD_IDX;
                     end else begin
                        cmd.op = OP_WALK_START;
                     end
                  end
                  REQ_DELETE_VALUE: begin
                     if (stat.empty) begin
                        cmd.op   = OP_REPORT;
                        cmd.code = STAT_EMPTY;
                     end else begin
                        cmd.op       = OP_WALK_START;
                        cmd.by_value = 1'b1;
                     end
                  end
                  default: begin
                     cmd.op   = OP_REPORT;
                     cmd.code = STAT_OK;
                  end
               endcase
               if (cmd.op == OP_WALK_START) begin
                  state_in = S_WALK;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_WALK: begin
            if (stat.walk_done) begin
               cmd.op       = OP_WALK_END;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.op = OP_WALK_STEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff == S_WALK);
   assign rsp_valid = rsp_valid_ff;

   `OLSD_ASSERT_IMPLIES(a_no_strobe_in_walk, clock, reset, state_ff == S_WALK, !rsp_valid_ff)
   `OLSD_ASSERT_NEXT(a_reply_follows, clock, reset, start && !busy && cmd.op != OP_WALK_START, rsp_valid_ff)
   `OLSD_ASSERT_NEXT(a_walk_holds_off, clock, reset, cmd.op == OP_WALK_START, busy && !rsp_valid_ff)

endmodule

### hw/rtl/olsd_dpath.sv
// ----------------------------------------------------------------------------
// olsd_dpath
// Entry memory kept as a ring with a head pointer, the entry count, the
// compaction walk pointers and the result registers.
// ----------------------------------------------------------------------------
`include "ordered_list_store_delete_ops_top_defines.svh"

module olsd_dpath
   import olsd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  logic signed [31:0] req_item_value,
   input  logic [3:0]         req_position,
   output dp_stat_type        stat,
   output logic [2:0]         rsp_status,
   output logic [4:0]         rsp_entry_count,
   output logic [4:0]         rsp_removed_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + 5;
   localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // ring address of the entry at a list position
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[AW-1:0];
   endfunction

   logic [31:0]   mem_ff [DEPTH];

   logic [AW-1:0] head_ff,     head_in;
   logic [CW-1:0] count_ff,    count_in;
   logic [CW-1:0] rd_idx_ff,   rd_idx_in;
   logic [CW-1:0] wr_idx_ff,   wr_idx_in;
   logic [CW-1:0] removed_ff,  removed_in;
   logic          p_valid_ff,  p_valid_in;
   logic [CW-1:0] p_idx_ff,    p_idx_in;
   logic [CW-1:0] pos_ff,      pos_in;
   logic [31:0]   key_ff,      key_in;
   logic          by_value_ff, by_value_in;
   status_type    status_ff,   status_in;
   logic [31:0]   rd_data_ff;

   logic [AW:0]   head_sum;
   logic [AW-1:0] head_inc;
   logic [AW-1:0] head_dec;
   logic [XW-1:0] pos_x;
   logic [XW-1:0] count_x;
   logic [XW-1:0] removed_x;
   logic          rd_issue;
   logic          proc;
   logic          keep;
   logic [CW-1:0] walk_start;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [AW-1:0] rd_addr;

   assign head_sum = {1'b0, head_ff} + (AW + 1)'(1);
   assign head_inc = (head_sum == DEPTH_X) ? '0 : head_sum[AW-1:0];
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   assign pos_x     = XW'(req_position);
   assign count_x   = XW'(count_ff);
   assign removed_x = XW'(removed_ff);

   assign rd_issue   = (cmd.op == OP_WALK_STEP) && (rd_idx_ff < count_ff);
   assign proc       = (cmd.op == OP_WALK_STEP) && p_valid_ff;
   assign keep       = by_value_ff ? (rd_data_ff != key_ff) : (p_idx_ff != pos_ff);
   assign walk_start = cmd.by_value ? '0 : pos_x[CW-1:0];
   assign rd_addr    = ring_addr(head_ff, rd_idx_ff[AW-1:0]);

   // one write port: new head on insert, kept entries during the walk
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = head_dec;
      mem_wdata = req_item_value;
      if (cmd.op == OP_INSERT) begin
         mem_we = 1'b1;
      end else if (proc && keep) begin
         mem_we    = 1'b1;
         mem_waddr = ring_addr(head_ff, wr_idx_ff[AW-1:0]);
         mem_wdata = rd_data_ff;
      end
   end

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      removed_in  = removed_ff;
      p_valid_in  = 1'b0;
      p_idx_in    = p_idx_ff;
      pos_in      = pos_ff;
      key_in      = key_ff;
      by_value_in = by_value_ff;
      status_in   = status_ff;
      case (cmd.op)
         OP_INSERT: begin
            head_in    = head_dec;
            count_in   = count_ff + CW'(1);
            status_in  = STAT_OK;
            removed_in = '0;
         end
         OP_POP_HEAD: begin
            head_in    = head_inc;
            count_in   = count_ff - CW'(1);
            status_in  = STAT_OK;
            removed_in = CW'(1);
         end
         OP_POP_TAIL: begin
            count_in   = count_ff - CW'(1);
            status_in  = STAT_OK;
            removed_in = CW'(1);
         end
         OP_REPORT: begin
            status_in  = cmd.code;
            removed_in = '0;
         end
         OP_WALK_START: begin
            by_value_in = cmd.by_value;
            key_in      = req_item_value;
            pos_in      = pos_x[CW-1:0];
            rd_idx_in   = walk_start;
            wr_idx_in   = walk_start;
            removed_in  = '0;
         end
         OP_WALK_STEP: begin
            // advance the read side, then file or drop the entry read last cycle
            if (rd_issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            p_valid_in = rd_issue;
            p_idx_in   = rd_idx_ff;
            if (proc) begin
               if (keep) begin
                  wr_idx_in = wr_idx_ff + CW'(1);
               end else begin
                  removed_in = removed_ff + CW'(1);
               end
            end
         end
         OP_WALK_END: begin
            count_in  = wr_idx_ff;
            status_in = (by_value_ff && removed_ff == '0) ? STAT_NOTFOUND : STAT_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         wr_idx_ff  <= wr_idx_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff  <= removed_in;
      p_idx_ff    <= p_idx_in;
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      by_value_ff <= by_value_in;
      status_ff   <= status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == DEPTH_C);
   assign stat.idx_bad   = (pos_x >= count_x);
   assign stat.walk_done = (rd_idx_ff >= count_ff) && !p_valid_ff;

   assign rsp_status        = status_ff;
   assign rsp_entry_count   = count_x[4:0];
   assign rsp_removed_count = removed_x[4:0];

   `OLSD_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_C)
   `OLSD_ASSERT_IMPLIES(a_write_behind_read, clock, reset, cmd.op == OP_WALK_STEP, wr_idx_ff <= rd_idx_ff)
   `OLSD_ASSERT_IMPLIES(a_pending_in_range, clock, reset, p_valid_ff, p_idx_ff < count_ff)

endmodule

### hw/rtl/ordered_list_store_delete_ops_top.sv
// ----------------------------------------------------------------------------
// ordered_list_store_delete_ops_top
// Bounded ordered list of signed 32-bit values, head at position 0, with
// insert-at-head and four kinds of delete. A transaction is taken when start
// is high and busy is low. Every transaction returns exactly one result,
// shown for a single cycle with rsp_valid high; the receiver cannot stall,
// so sample it in that cycle. Insert, delete head, delete tail, any request
// refused for an empty or full list or a bad index, and unused request kinds
// finish at once: the result appears the cycle after acceptance and busy
// stays low, so one such transaction may be taken every cycle. Delete at
// index and delete by value compact the list through the entry memory, one
// entry per cycle over its single read port and single write port: busy is
// high while the walk runs, and the result appears in the cycle in which
// busy falls. entry_count and removed_count carry the low five bits of the
// counts. Entries are never cleared; the list is empty after reset.
// ----------------------------------------------------------------------------
module ordered_list_store_delete_ops_top
   import olsd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_item_value,
   input  logic [3:0]         req_position,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [4:0]         rsp_entry_count,
   output logic [4:0]         rsp_removed_count
);

   // command and status bundles between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: decode each transaction, run the walk, strobe the result
   olsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: ring memory, count, walk pointers and result registers
   olsd_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_item_value    (req_item_value),
      .req_position      (req_position),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_removed_count (rsp_removed_count)
   );

endmodule

### tb/tb_ordered_list_store_delete_ops_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the ordered list store with delete operations
// Drives insert and delete transactions through the start/busy handshake and
// keeps a shadow copy of the list, from which the status, entry count and
// removed count of every response are predicted and compared in order.
// ----------------------------------------------------------------------------
module tb_ordered_list_store_delete_ops_top;
   import olsd_pkg::*;

   localparam int LIST_DEPTH      = 16;
   localparam int RANDOM_REQUESTS = 1420;
   localparam int DRAIN_CYCLES    = 24;
   localparam int MAX_REPORTS     = 10;

   // request kinds beyond the package enum; the block treats them as no-ops
   localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;

   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      status_type status;
      logic [4:0] entry_count;
      logic [4:0] removed_count;
   } list_outcome_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_type;
   logic signed [31:0] req_item_value;
   logic [3:0]         req_position;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [4:0]         rsp_entry_count;
   logic [4:0]         rsp_removed_count;

   ordered_list_store_delete_ops_top #(
      .DEPTH (LIST_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_removed_count (rsp_removed_count)
   );

   // Shadow of the list held by the block: packed at 0 .. shadow_len-1
   logic signed [31:0] shadow_list [LIST_DEPTH];
   int                 shadow_len;

   // Outcomes predicted at acceptance, oldest first
   list_outcome_type   pending_outcomes [$];

   // Pool of values reused within a random segment so that deletes by value
   // find duplicates, adjacent matches and leading matches
   logic signed [31:0] value_pool [4];
   bit                 no_idle;

   int mismatch_count;
   int responses_checked;
   int requests_sent;
   int insert_count;
   int full_refusals;
   int multi_removals;
   int index_deletes;
   int deepest_list;

   // ------------------------------------------------------------------------
   // Clock: 4 ns period
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Close the gap left at idx, keeping the order of the survivors
   function automatic void close_gap(int idx);
      for (int i = idx; i + 1 < shadow_len; i++)
         shadow_list[i] = shadow_list[i + 1];
      shadow_len--;
   endfunction

   // Apply one transaction to the shadow list and return what the block
   // should report for it
   function automatic list_outcome_type apply_request(logic [2:0] kind,
                                                      logic signed [31:0] value,
                                                      logic [3:0] pos);
      list_outcome_type res;
      int               kept;
      int               dropped;
      res.status = STAT_OK;
      dropped    = 0;
      case (kind)
         REQ_INSERT_HEAD: begin
            if (shadow_len >= LIST_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               for (int i = shadow_len; i > 0; i--)
                  shadow_list[i] = shadow_list[i - 1];
               shadow_list[0] = value;
               shadow_len++;
            end
         end
         REQ_DELETE_HEAD: begin
            if (shadow_len == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               close_gap(0);
               dropped = 1;
            end
         end
         REQ_DELETE_TAIL: begin
            if (shadow_len == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               shadow_len--;
               dropped = 1;
            end
         end
         REQ_DELETE_INDEX: begin
            if (shadow_len == 0) begin
               res.status = STAT_EMPTY;
            end else if (int'(pos) >= shadow_len) begin
               res.status = STAT_BAD_IDX;
            end else begin
               close_gap(int'(pos));
               dropped = 1;
            end
         end
         REQ_DELETE_VALUE: begin
            if (shadow_len == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               kept = 0;
               for (int i = 0; i < shadow_len; i++) begin
                  if (shadow_list[i] == value) begin
                     dropped++;
                  end else begin
                     shadow_list[kept] = shadow_list[i];
                     kept++;
                  end
               end
               shadow_len = kept;
               if (dropped == 0)
                  res.status = STAT_NOTFOUND;
            end
         end
         default: ;
      endcase
      res.entry_count   = 5'(shadow_len);
      res.removed_count = 5'(dropped);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Idle cycles after a transaction: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle)  return 0;
      if (r < 55)   return 0;
      if (r < 85)   return $urandom_range(1, 3);
      if (r < 97)   return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return value_pool[$urandom_range(0, 3)];
      if (r < 70) return VALUE_MIN;
      if (r < 80) return VALUE_MAX;
      return $urandom;
   endfunction

   // Send one transaction: hold start and the fields until the block takes
   // them, record the predicted outcome, then idle for gap cycles. With no
   // gap start stays high so the next transaction follows straight on.
   task automatic send_request(logic [2:0] kind, logic signed [31:0] value,
                               logic [3:0] pos, int gap);
      list_outcome_type outcome;
      req_type       <= kind;
      req_item_value <= value;
      req_position   <= pos;
      start          <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      outcome = apply_request(kind, value, pos);
      pending_outcomes.push_back(outcome);
      requests_sent++;
      if (kind == REQ_INSERT_HEAD)  insert_count++;
      if (kind == REQ_DELETE_INDEX) index_deletes++;
      if (outcome.status == STAT_FULL) full_refusals++;
      if (outcome.removed_count > 1) multi_removals++;
      if (shadow_len > deepest_list) deepest_list = shadow_len;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every outstanding response has come back
   task automatic wait_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Response checker: the receiver cannot stall, so take every strobed
   // response at the edge that ends its cycle
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : check_responses
      list_outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no transaction outstanding (status)",
                            0, rsp_status);
         end else begin
            want = pending_outcomes.pop_front();
            responses_checked++;
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", want.entry_count, rsp_entry_count);
            if (rsp_removed_count !== want.removed_count)
               report_mismatch("removed_count", want.removed_count, rsp_removed_count);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Every delete on an empty list is refused; an unused kind is a no-op
   task automatic test_empty_list_refusals();
      send_request(REQ_DELETE_HEAD,  32'sd0, 4'd0, pick_gap());
      send_request(REQ_DELETE_TAIL,  32'sd0, 4'd0, pick_gap());
      send_request(REQ_DELETE_INDEX, 32'sd0, 4'd0, pick_gap());
      send_request(REQ_DELETE_VALUE, 32'sd0, 4'd0, pick_gap());
      send_request(REQ_RESERVED_FIRST, VALUE_MAX, 4'hf, pick_gap());
   endtask

   // Fill to the limit with extremes and duplicates, then insert once more
   // to see the full refusal. The list ends as 7, 7, eight random values, -1, 0, 7, min, max, 7.
   task automatic test_fill_to_full();
      send_request(REQ_INSERT_HEAD, 32'sd7, 4'd0, pick_gap());
      send_request(REQ_INSERT_HEAD, VALUE_MAX, 4'd0, pick_gap());
      send_request(REQ_INSERT_HEAD, VALUE_MIN, 4'd0, pick_gap());
      send_request(REQ_INSERT_HEAD, 32'sd7, 4'd0, pick_gap());
      send_request(REQ_INSERT_HEAD, 32'sd0, 4'd0, pick_gap());
      send_request(REQ_INSERT_HEAD, -32'sd1, 4'd0, pick_gap());
      repeat (8) send_request(REQ_INSERT_HEAD, $urandom, 4'd0, pick_gap());
      send_request(REQ_INSERT_HEAD, 32'sd7, 4'd0, pick_gap());
      send_request(REQ_INSERT_HEAD, 32'sd7, 4'd0, pick_gap());
      send_request(REQ_INSERT_HEAD, -32'sd1, 4'd0, pick_gap());
   endtask

   // Delete at the last and first index, past the end, and by value with
   // leading and adjacent matches, then again with the value absent
   task automatic test_delete_cases();
      send_request(REQ_DELETE_INDEX, 32'sd0, 4'd15, pick_gap());
      send_request(REQ_DELETE_VALUE, 32'sd7, 4'd0, pick_gap());
      send_request(REQ_DELETE_VALUE, 32'sd7, 4'd0, pick_gap());
      send_request(REQ_DELETE_INDEX, 32'sd0, 4'd15, pick_gap());
      send_request(REQ_DELETE_INDEX, 32'sd0, 4'd0, pick_gap());
      send_request(REQ_RESERVED_LAST, VALUE_MIN, 4'd3, pick_gap());
      send_request(REQ_DELETE_TAIL, 32'sd0, 4'd0, pick_gap());
      send_request(REQ_DELETE_HEAD, 32'sd0, 4'd0, pick_gap());
   endtask

   // Random traffic in segments. Each segment draws a fresh value pool and an
   // insert weight, so the list swings between empty and full; deletes by
   // value and index mostly aim at entries that are present.
   task automatic test_random_traffic();
      int          remaining;
      int          seg_len;
      int          insert_weight;
      int          r;
      logic [2:0]  kind;
      logic signed [31:0] value;
      logic [3:0]  pos;
      remaining = RANDOM_REQUESTS;
      while (remaining > 0) begin
         seg_len = $urandom_range(20, 60);
         if (seg_len > remaining) seg_len = remaining;
         case ($urandom_range(0, 2))
            0:       insert_weight = 25;
            1:       insert_weight = 45;
            default: insert_weight = 75;
         endcase
         foreach (value_pool[i]) value_pool[i] = $urandom;
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            r     = $urandom_range(0, 99);
            value = pick_value();
            pos   = 4'($urandom_range(0, LIST_DEPTH - 1));
            if (r < insert_weight) begin
               kind = REQ_INSERT_HEAD;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 4)       kind = 3'($urandom_range(REQ_RESERVED_FIRST,
                                                          REQ_RESERVED_LAST));
               else if (r < 20) kind = REQ_DELETE_HEAD;
               else if (r < 36) kind = REQ_DELETE_TAIL;
               else if (r < 68) kind = REQ_DELETE_INDEX;
               else             kind = REQ_DELETE_VALUE;
            end
            // aim at an entry that is held, most of the time
            if (shadow_len > 0 && $urandom_range(0, 99) < 75) begin
               if (kind == REQ_DELETE_VALUE)
                  value = shadow_list[$urandom_range(0, shadow_len - 1)];
               if (kind == REQ_DELETE_INDEX)
                  pos = 4'($urandom_range(0, shadow_len - 1));
            end
            send_request(kind, value, pos, pick_gap());
         end
         remaining -= seg_len;
         // now and then let everything drain before the next segment
         if ($urandom_range(0, 5) == 0)
            wait_until_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // Initialise every input and hold reset, then release it
      reset             <= 1'b1;
      start             <= 1'b0;
      req_type          <= REQ_INSERT_HEAD;
      req_item_value    <= 32'sd0;
      req_position      <= 4'd0;
      shadow_len        = 0;
      no_idle           = 1'b0;
      mismatch_count    = 0;
      responses_checked = 0;
      requests_sent     = 0;
      insert_count      = 0;
      full_refusals     = 0;
      multi_removals    = 0;
      index_deletes     = 0;
      deepest_list      = 0;
      foreach (value_pool[i]) value_pool[i] = 32'sd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_list_refusals();
      test_fill_to_full();
      test_delete_cases();
      // Hold the sender until the directed transactions are all answered
      wait_until_drained();
      test_random_traffic();

      // Drain, then allow a few more cycles for any stray response
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transactions: %0d inserts (%0d refused as full), %0d index deletes,",
               requests_sent, insert_count, full_refusals, index_deletes);
      $display("%0d multi-entry value deletes, deepest list %0d; %0d responses checked.",
               multi_removals, deepest_list, responses_checked);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Watchdog: far beyond the slowest legal run
   // ------------------------------------------------------------------------
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/olsd_pkg.sv
hw/rtl/olsd_ctrl.sv
hw/rtl/olsd_dpath.sv
hw/rtl/ordered_list_store_delete_ops_top.sv
tb/tb_ordered_list_store_delete_ops_top.sv
